>>> src/vrf_pkg.sv
package vrf_pkg;

  localparam int FracShift = 12;
  localparam int ChanCount = 4;
  localparam int AccWidth = 32;
  localparam int ProdWidth = 25;

  localparam logic [AccWidth-1:0] RoundInit = AccWidth'(1) << (FracShift - 1);

  typedef struct packed {
    logic [7:0]         chan0;
    logic [7:0]         chan1;
    logic [7:0]         chan2;
    logic [7:0]         chan3;
    logic signed [15:0] coeff;
    logic               last_tap;
    logic               last_column;
  } tap_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic       row_end;
  } pix_t;

  // arithmetic shift by the fraction width, then saturate to a byte
  function automatic logic [7:0] clamp_byte(input logic [AccWidth-1:0] sum);
    logic signed [AccWidth-1:0] shifted;
    logic [7:0] res;
    shifted = $signed(sum) >>> FracShift;
    if (shifted[AccWidth-1]) begin
      res = 8'd0;
    end else if (shifted[AccWidth-1:8] != '0) begin
      res = 8'hff;
    end else begin
      res = shifted[7:0];
    end
    return res;
  endfunction

endpackage

>>> src/vrf_tap_if.sv
interface vrf_tap_if;
  logic           valid;
  logic           ready;
  vrf_pkg::tap_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/vrf_pix_if.sv
interface vrf_pix_if;
  logic           valid;
  logic           ready;
  vrf_pkg::pix_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/vertical_resample_fir_rgba8_core.sv
// Vertical filter tap engine for four-channel 8-bit pixels.
// taps (sink): one source pixel plus its signed 16-bit weight per transaction,
//   with last_tap closing an output pixel and last_column marking the row end.
// pixels (source): one filtered pixel per last_tap transaction; row_end copies
//   the last_column bit of that tap.
// Throughput: one tap per clock. Four 8x16 multipliers feed four 32-bit
//   accumulators; multiply, accumulate and saturate all sit between the input
//   register and the result register.
// Path: a last_tap transaction is captured in the input register, and its pixel
//   is written to the result register once that is free (two register stages).
// Reset: input register emptied, result invalid, accumulators loaded with the
//   rounding constant 2^(FracShift-1).
// Receiver stall: the result register holds its pixel; taps that do not close
//   a pixel keep flowing and accumulating. A closing tap waits in the input
//   register until the result register frees, and the input side backs up
//   while it waits.
module vertical_resample_fir_rgba8_core (
  input  logic          clk,
  input  logic          rst,
  vrf_tap_if.sink       taps,
  vrf_pix_if.source     pixels
);

  // input stage
  logic                        s1_valid;
  logic [7:0]                  s1_chan [vrf_pkg::ChanCount];
  logic signed [15:0]          s1_coeff;
  logic                        s1_last;
  logic                        s1_col;

  logic signed [vrf_pkg::ProdWidth-1:0] prod [vrf_pkg::ChanCount];

  logic [vrf_pkg::AccWidth-1:0] acc [vrf_pkg::ChanCount];
  logic [vrf_pkg::AccWidth-1:0] acc_sum [vrf_pkg::ChanCount];

  logic                        out_valid;
  vrf_pkg::pix_t               out_data;

  logic out_free;
  logic s1_consume;
  logic s1_open;
  logic in_fire;

  assign out_free   = !out_valid || pixels.ready;
  assign s1_consume = s1_valid && (!s1_last || out_free);
  assign s1_open    = !s1_valid || s1_consume;
  assign in_fire    = taps.valid && s1_open;

  assign taps.ready   = s1_open;
  assign pixels.valid = out_valid;
  assign pixels.data  = out_data;

  always_comb begin
    for (int i = 0; i < vrf_pkg::ChanCount; i++) begin
      prod[i]    = $signed({1'b0, s1_chan[i]}) * s1_coeff;
      acc_sum[i] = acc[i] + vrf_pkg::AccWidth'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= taps.valid;
    end
    if (in_fire) begin
      s1_chan[0] <= taps.data.chan0;
      s1_chan[1] <= taps.data.chan1;
      s1_chan[2] <= taps.data.chan2;
      s1_chan[3] <= taps.data.chan3;
      s1_coeff   <= taps.data.coeff;
      s1_last    <= taps.data.last_tap;
      s1_col     <= taps.data.last_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vrf_pkg::ChanCount; i++) begin
        acc[i] <= vrf_pkg::RoundInit;
      end
    end else if (s1_consume) begin
      for (int i = 0; i < vrf_pkg::ChanCount; i++) begin
        acc[i] <= s1_last ? vrf_pkg::RoundInit : acc_sum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && s1_last;
    end
    if (out_free && s1_valid && s1_last) begin
      out_data.out0    <= vrf_pkg::clamp_byte(acc_sum[0]);
      out_data.out1    <= vrf_pkg::clamp_byte(acc_sum[1]);
      out_data.out2    <= vrf_pkg::clamp_byte(acc_sum[2]);
      out_data.out3    <= vrf_pkg::clamp_byte(acc_sum[3]);
      out_data.row_end <= s1_col;
    end
  end

  // accumulators restart at the rounding constant once a pixel is closed
  a_acc_restart: assert property (@(posedge clk) disable iff (rst)
    s1_consume && s1_last |=> acc[0] == vrf_pkg::RoundInit
      && acc[1] == vrf_pkg::RoundInit && acc[2] == vrf_pkg::RoundInit
      && acc[3] == vrf_pkg::RoundInit)
    else $error("accumulators not restarted after closing tap");

  // a new pixel only comes from a closing tap in the input register
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result appeared without a closing tap");

  // input backs up only behind a closing tap facing a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !taps.ready |-> s1_valid && s1_last && out_valid && !pixels.ready)
    else $error("input stalled with room in the pipeline");

  // a non-closing tap never waits on the result register
  a_no_stall_mid: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |-> s1_consume)
    else $error("accumulating tap held back");

  // a stalled pixel stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixels.ready |=> out_valid && $stable(out_data))
    else $error("pixel changed while stalled");

endmodule

>>> bench/vertical_resample_fir_rgba8_core_tb.sv
`timescale 1ns / 1ps

module vertical_resample_fir_rgba8_core_tb;

  typedef struct packed {
    vrf_pkg::tap_t stim;
    logic typed;
    vrf_pkg::pix_t want;
  } check_row_t;

  localparam int DirectedRows = 15;
  localparam int RandomTaps = 330;
  localparam int OverflowTaps = 260;
  localparam int LongHold = 200;

  // typed rows carry a pixel that can be read off directly; others use the predictor
  localparam check_row_t DirectedTable [DirectedRows] = '{
    '{'{8'd0, 8'd0, 8'd0, 8'd0, 16'sd0, 1'b1, 1'b0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 16'sd4096, 1'b1, 1'b1}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 16'h7fff, 1'b1, 1'b0}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 16'h8000, 1'b1, 1'b1}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
    '{'{8'd1, 8'd2, 8'd128, 8'd255, 16'sd4096, 1'b1, 1'b0}, 1'b1,
      '{8'd1, 8'd2, 8'd128, 8'd255, 1'b0}},
    // row-end bit on a non-closing tap must not reach the pixel
    '{'{8'd10, 8'd20, 8'd30, 8'd40, 16'sd2048, 1'b0, 1'b1}, 1'b0, '0},
    '{'{8'd10, 8'd20, 8'd30, 8'd40, 16'sd2048, 1'b1, 1'b0}, 1'b1,
      '{8'd10, 8'd20, 8'd30, 8'd40, 1'b0}},
    '{'{8'd100, 8'd50, 8'd200, 8'd0, -16'sd1024, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd120, 8'd60, 8'd180, 8'd255, 16'sd6144, 1'b0, 1'b1}, 1'b0, '0},
    '{'{8'd90, 8'd70, 8'd160, 8'd128, -16'sd1024, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'haa, 8'h55, 8'hf0, 8'h0f, 16'h5555, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h55, 8'haa, 8'h0f, 8'hf0, 16'haaaa, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 16'hffff, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 16'h0001, 1'b1, 1'b1}, 1'b0, '0},
    // exactly one half after the shift rounds up
    '{'{8'd1, 8'd1, 8'd1, 8'd1, 16'sd2048, 1'b1, 1'b0}, 1'b0, '0}
  };

  logic clk;
  logic rst;

  vrf_tap_if tap_bus ();
  vrf_pix_if pix_bus ();

  vertical_resample_fir_rgba8_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .taps   (tap_bus),
    .pixels (pix_bus)
  );

  logic [vrf_pkg::AccWidth-1:0] chan_acc [vrf_pkg::ChanCount];
  vrf_pkg::pix_t expected_pixels [$];
  int mismatches = 0;
  bit hold_pixels = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("vertical_resample_fir_rgba8_core: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // multiply-accumulate one tap; on a closing tap produce the pixel and reload
  function automatic bit accumulate_tap(input vrf_pkg::tap_t t, output vrf_pkg::pix_t px);
    logic [7:0] ch [vrf_pkg::ChanCount];
    logic [7:0] res [vrf_pkg::ChanCount];
    logic signed [vrf_pkg::AccWidth-1:0] prod;
    logic signed [vrf_pkg::AccWidth-1:0] q;
    ch = '{t.chan0, t.chan1, t.chan2, t.chan3};
    for (int i = 0; i < vrf_pkg::ChanCount; i++) begin
      prod = $signed(32'(ch[i])) * 32'(t.coeff);
      chan_acc[i] = chan_acc[i] + prod;
    end
    px = '0;
    if (!t.last_tap) begin
      return 1'b0;
    end
    for (int i = 0; i < vrf_pkg::ChanCount; i++) begin
      q = $signed(chan_acc[i]) >>> vrf_pkg::FracShift;
      if (q < 0) begin
        res[i] = 8'd0;
      end else if (q > 255) begin
        res[i] = 8'hff;
      end else begin
        res[i] = q[7:0];
      end
      chan_acc[i] = vrf_pkg::RoundInit;
    end
    px = '{res[0], res[1], res[2], res[3], t.last_column};
    return 1'b1;
  endfunction

  // idle cycles before the next transaction, with occasional back-to-back bursts
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  int tap_burst = 0;

  task automatic send_tap(input vrf_pkg::tap_t t, input bit typed, input vrf_pkg::pix_t want);
    int gap;
    vrf_pkg::pix_t px;
    gap = draw_gap(tap_burst);
    if (gap > 0) begin
      tap_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tap_bus.valid <= 1'b1;
    tap_bus.data <= t;
    @(negedge clk);
    while (!tap_bus.ready) @(negedge clk);
    @(posedge clk);
    if (accumulate_tap(t, px)) begin
      expected_pixels.push_back(typed ? want : px);
    end
  endtask

  initial begin : pixel_sink
    int stall;
    int pixel_burst;
    pixel_burst = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_pixels) begin
        stall = LongHold;
        hold_pixels = 1'b0;
      end else begin
        stall = draw_gap(pixel_burst);
      end
      if (stall > 0) begin
        pix_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_bus.ready <= 1'b1;
      @(negedge clk);
      while (!pix_bus.valid) @(negedge clk);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : pixel_check
    vrf_pkg::pix_t want;
    logic [7:0] got_f [5];
    logic [7:0] want_f [5];
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %h with none pending", pix_bus.data));
      end else begin
        want = expected_pixels.pop_front();
        got_f = '{pix_bus.data.out0, pix_bus.data.out1, pix_bus.data.out2,
                  pix_bus.data.out3, 8'(pix_bus.data.row_end)};
        want_f = '{want.out0, want.out1, want.out2, want.out3, 8'(want.row_end)};
        for (int f = 0; f < 5; f++) begin
          if (got_f[f] !== want_f[f]) begin
            report_mismatch($sformatf("field %0d: got %0d, want %0d",
                                      f, got_f[f], want_f[f]));
          end
        end
      end
    end
  end

  initial begin
    vrf_pkg::tap_t t;
    logic [7:0] ch [vrf_pkg::ChanCount];
    logic [15:0] cf;
    int sent;
    int len;
    rst = 1'b1;
    tap_bus.valid = 1'b0;
    tap_bus.data = '0;
    pix_bus.ready = 1'b0;
    for (int i = 0; i < vrf_pkg::ChanCount; i++) begin
      chan_acc[i] = vrf_pkg::RoundInit;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DirectedRows; r++) begin
      send_tap(DirectedTable[r].stim, DirectedTable[r].typed, DirectedTable[r].want);
    end

    // one long pixel at full weight: the sum wraps past the top, then back past the bottom
    for (int k = 0; k < OverflowTaps; k++) begin
      t = '{8'hff, 8'hff, 8'hff, 8'hff, (k < OverflowTaps - 2) ? 16'h7fff : 16'h8000,
            k == OverflowTaps - 1, 1'b1};
      send_tap(t, 1'b0, '0);
    end

    sent = 0;
    while (sent < RandomTaps) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        for (int i = 0; i < vrf_pkg::ChanCount; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            ch[i] = $urandom_range(0, 1) ? 8'hff : 8'h00;
          end else begin
            ch[i] = 8'($urandom);
          end
        end
        case ($urandom_range(0, 9))
          0, 1: cf = 16'($urandom);
          2: begin
            case ($urandom_range(0, 5))
              0: cf = 16'h8000;
              1: cf = 16'h7fff;
              2: cf = 16'hffff;
              3: cf = 16'h0000;
              4: cf = 16'h0001;
              default: cf = 16'h1000;
            endcase
          end
          default: cf = 16'($urandom_range(0, 8191) - 2048);
        endcase
        t = '{ch[0], ch[1], ch[2], ch[3], cf, k == len - 1, 1'($urandom)};
        // one long receiver hold while the taps keep coming
        if (sent == RandomTaps / 2) begin
          hold_pixels = 1'b1;
        end
        send_tap(t, 1'b0, '0);
        sent++;
      end
    end
    tap_bus.valid <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("vertical_resample_fir_rgba8_core: match");
    end else begin
      $display("vertical_resample_fir_rgba8_core: mismatch");
    end
    $finish;
  end

endmodule

>>> vertical_resample_fir_rgba8_core.f
src/vrf_pkg.sv
src/vrf_tap_if.sv
src/vrf_pix_if.sv
src/vertical_resample_fir_rgba8_core.sv
bench/vertical_resample_fir_rgba8_core_tb.sv
